### rtl/core/scm_pkg.sv
// Shared constants for the sorted counting multiset.
package scm_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int COUNT_BITS_DEF  = 21;
	localparam int KEY_BITS        = 31;
	localparam int OUT_COUNT_BITS  = 20;
	localparam int TDATA_BITS      = 56;
	localparam int TUSER_BITS      = 2;

	// Largest count a result can report.
	localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX = {OUT_COUNT_BITS{1'b1}};

endpackage

### rtl/core/scm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/sorted_counting_multiset.sv
// Top level of the sorted counting multiset: sequencer around one table RAM.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+---------------------------------------------
//  s_*     | in  | s_tvalid/tready  | s_tdata[31:0] number_in (signed)
//  m_*     | out | m_tvalid/tready  | m_tdata key_value, key_count; tuser; tlast
//
// Steps: an add or remove scans the sorted table, reading then comparing each
// entry, then shifts the entries behind the slot, reading then writing each one.
// A dump reads and checks each held entry in turn and waits on any output stall.
// Reset clears the entry count, the overflow flag, the sequencer and the valid flags; no clearing pass.
// Input stalls until the request is done; a dump runs one result ahead of a stalled output.
module sorted_counting_multiset #(
	parameter int TABLE_DEPTH = scm_pkg::TABLE_DEPTH_DEF,
	parameter int COUNT_BITS  = scm_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [31:0]                      s_tdata,  // [31:0] number_in
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [scm_pkg::TDATA_BITS-1:0]   m_tdata,  // [30:0] key_value, [50:31] key_count
	output logic [scm_pkg::TUSER_BITS-1:0]   m_tuser,  // [0] item_valid, [1] table_overflow
	output logic                             m_tlast   // last_item
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int KB = scm_pkg::KEY_BITS;
	localparam int OB = scm_pkg::OUT_COUNT_BITS;
	localparam int DW = KB + COUNT_BITS;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
	localparam logic signed [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
	localparam logic signed [COUNT_BITS-1:0] CNT_NEG = {COUNT_BITS{1'b1}};
	localparam logic signed [32:0] OUT_MAX_EXT = 33'(scm_pkg::OUT_COUNT_MAX);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SRD    = 4'd1;
	localparam logic [3:0] ST_SCMP   = 4'd2;
	localparam logic [3:0] ST_UPD    = 4'd3;
	localparam logic [3:0] ST_RM_RD  = 4'd4;
	localparam logic [3:0] ST_RM_WR  = 4'd5;
	localparam logic [3:0] ST_IN_RD  = 4'd6;
	localparam logic [3:0] ST_IN_WR  = 4'd7;
	localparam logic [3:0] ST_D_RD   = 4'd8;
	localparam logic [3:0] ST_D_CHK  = 4'd9;
	localparam logic [3:0] ST_D_FIN  = 4'd10;

	logic [3:0]    state_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pos_q;
	logic          overflow_q;
	logic [KB-1:0] key_q;
	logic          inc_q;

	logic          pend_v_q;
	logic [KB-1:0] pend_key_q;
	logic [OB-1:0] pend_cnt_q;

	logic          m_tvalid_q;
	logic [KB-1:0] out_key_q;
	logic [OB-1:0] out_cnt_q;
	logic          out_item_q;
	logic          out_ovf_q;
	logic          out_last_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [DW-1:0] ram_rdata;

	logic [KB-1:0]                  rd_key;
	logic signed [COUNT_BITS-1:0]   rd_cnt;
	logic signed [COUNT_BITS-1:0]   new_cnt;
	logic signed [32:0]             rd_cnt_ext;
	logic [OB-1:0]                  rd_cnt_cap;
	logic                           out_free;
	logic                           dump_take;
	logic                           out_load;
	logic [CW-1:0]                  idx_inc;
	logic [CW-1:0]                  idx_dec;
	logic [CW:0]                    idx_inc_w;
	logic [31:0]                    neg_in;

	scm_ram #(
		.WIDTH (DW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Split the entry read back and work out the count arithmetic
	assign rd_key     = ram_rdata[DW-1:COUNT_BITS];
	assign rd_cnt     = $signed(ram_rdata[COUNT_BITS-1:0]);
	assign rd_cnt_ext = 33'(rd_cnt);
	assign rd_cnt_cap = (rd_cnt_ext > OUT_MAX_EXT) ? scm_pkg::OUT_COUNT_MAX : rd_cnt_ext[OB-1:0];
	assign idx_inc    = idx_q + 1'b1;
	assign idx_dec    = idx_q - 1'b1;
	assign idx_inc_w  = {1'b0, idx_q} + 1'b1;
	assign neg_in     = ~s_tdata + 1'b1;
	assign out_free   = !m_tvalid_q || m_tready;

	// Take a positive entry into the pending slot; load the output on a handoff or close
	assign dump_take = (state_q == ST_D_CHK) && (rd_cnt > $signed(COUNT_BITS'(0)))
		&& (!pend_v_q || out_free);
	assign out_load  = (dump_take && pend_v_q) || (state_q == ST_D_FIN && out_free);

	always_comb begin
		if (inc_q) begin
			new_cnt = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + CNT_ONE;
		end else begin
			new_cnt = (rd_cnt == CNT_MIN) ? rd_cnt : rd_cnt - CNT_ONE;
		end
	end

	// Drive the RAM ports from the sequencer state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[AW-1:0];
		unique case (state_q) inside
			ST_UPD: begin
				ram_we    = (new_cnt != '0);
				ram_wdata = {key_q, new_cnt};
			end
			ST_RM_RD, ST_RM_WR: begin
				ram_raddr = idx_inc[AW-1:0];
				ram_we    = (state_q == ST_RM_WR);
			end
			ST_IN_RD: begin
				ram_raddr = idx_dec[AW-1:0];
				ram_we    = (idx_q == pos_q);
				ram_wdata = {key_q, inc_q ? CNT_ONE : CNT_NEG};
			end
			ST_IN_WR: begin
				ram_raddr = idx_dec[AW-1:0];
				ram_we    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequence each request through search, update, shift and dump steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			used_q     <= '0;
			idx_q      <= '0;
			pos_q      <= '0;
			overflow_q <= 1'b0;
			pend_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// load the output register, or release it once taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						idx_q    <= '0;
						pend_v_q <= 1'b0;
						if (s_tdata == 32'd0) begin
							state_q <= ST_D_RD;
						end else if (s_tdata != 32'h8000_0000) begin
							state_q <= ST_SRD;
						end
					end
				end
				ST_SRD: begin
					if (idx_q == used_q) begin
						// key absent and larger than all held keys
						pos_q <= idx_q;
						if (used_q == DEPTH_C) begin
							overflow_q <= 1'b1;
							state_q    <= ST_IDLE;
						end else begin
							idx_q   <= used_q;
							state_q <= ST_IN_RD;
						end
					end else begin
						state_q <= ST_SCMP;
					end
				end
				ST_SCMP: begin
					if (rd_key < key_q) begin
						idx_q   <= idx_inc;
						state_q <= ST_SRD;
					end else if (rd_key == key_q) begin
						state_q <= ST_UPD;
					end else begin
						pos_q <= idx_q;
						if (used_q == DEPTH_C) begin
							overflow_q <= 1'b1;
							state_q    <= ST_IDLE;
						end else begin
							idx_q   <= used_q;
							state_q <= ST_IN_RD;
						end
					end
				end
				ST_UPD: begin
					state_q <= (new_cnt != '0) ? ST_IDLE : ST_RM_RD;
				end
				ST_RM_RD: begin
					if (idx_inc_w >= {1'b0, used_q}) begin
						used_q  <= used_q - 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RM_WR;
					end
				end
				ST_RM_WR: begin
					idx_q   <= idx_inc;
					state_q <= ST_RM_RD;
				end
				ST_IN_RD: begin
					if (idx_q == pos_q) begin
						used_q  <= used_q + 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_IN_WR;
					end
				end
				ST_IN_WR: begin
					idx_q   <= idx_dec;
					state_q <= ST_IN_RD;
				end
				ST_D_RD: begin
					state_q <= (idx_q == used_q) ? ST_D_FIN : ST_D_CHK;
				end
				ST_D_CHK: begin
					if (rd_cnt > $signed(COUNT_BITS'(0))) begin
						// hold until the previous pending item can leave
						if (dump_take) begin
							pend_v_q <= 1'b1;
							idx_q    <= idx_inc;
							state_q  <= ST_D_RD;
						end
					end else begin
						idx_q   <= idx_inc;
						state_q <= ST_D_RD;
					end
				end
				ST_D_FIN: begin
					if (out_free) begin
						pend_v_q   <= 1'b0;
						used_q     <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the request key and the dump payloads
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			key_q <= s_tdata[31] ? neg_in[KB-1:0] : s_tdata[KB-1:0];
			inc_q <= !s_tdata[31];
		end
		if (dump_take) begin
			pend_key_q <= rd_key;
			pend_cnt_q <= rd_cnt_cap;
		end
		if (dump_take && pend_v_q) begin
			out_key_q  <= pend_key_q;
			out_cnt_q  <= pend_cnt_q;
			out_item_q <= 1'b1;
			out_ovf_q  <= overflow_q;
			out_last_q <= 1'b0;
		end
		if (state_q == ST_D_FIN && out_free) begin
			out_key_q  <= pend_v_q ? pend_key_q : '0;
			out_cnt_q  <= pend_v_q ? pend_cnt_q : '0;
			out_item_q <= pend_v_q;
			out_ovf_q  <= overflow_q;
			out_last_q <= 1'b1;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(scm_pkg::TDATA_BITS-KB-OB){1'b0}}, out_cnt_q, out_key_q};
	assign m_tuser  = {out_ovf_q, out_item_q};
	assign m_tlast  = out_last_q;

	// The entry count never passes the table depth
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= DEPTH_C)
		else $error("entry count above table depth");

	// Overflow stays set once raised
	a_overflow_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |=> overflow_q)
		else $error("overflow flag cleared");

	// Table writes stay within the held entries plus one insert slot
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ({1'b0, ram_waddr} < {1'b0, used_q} + 1'b1))
		else $error("table write beyond held entries");

	// Closing a dump empties the table and marks the last result
	a_dump_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_D_FIN && out_free) |=> (used_q == '0 && m_tvalid_q && out_last_q))
		else $error("dump close did not clear table");

endmodule

### verif/multiset_checker.sv
// Checker for the sorted counting multiset: tracks the table, predicts dump items, compares.
module multiset_checker #(
	parameter int TABLE_DEPTH = scm_pkg::TABLE_DEPTH_DEF,
	parameter int COUNT_BITS  = scm_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [31:0]                    s_tdata,  // [31:0] number_in
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [scm_pkg::TDATA_BITS-1:0] m_tdata,  // [30:0] key_value, [50:31] key_count
	input  logic [scm_pkg::TUSER_BITS-1:0] m_tuser,  // [0] item_valid, [1] table_overflow
	input  logic                           m_tlast,  // last_item
	output int                             errors,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     KB     = scm_pkg::KEY_BITS;
	localparam int     OCB    = scm_pkg::OUT_COUNT_BITS;
	localparam longint CNT_HI = (longint'(1) <<< (COUNT_BITS - 1)) - 1;
	localparam longint CNT_LO = -CNT_HI - 1;

	typedef struct packed {
		logic [KB-1:0]  key;
		logic [OCB-1:0] cnt;
		logic           valid;
		logic           ovf;
		logic           last;
	} dump_item_t;

	// Shadow copy of the sorted key table
	logic [KB-1:0]                tally_key [TABLE_DEPTH];
	logic signed [COUNT_BITS-1:0] tally_cnt [TABLE_DEPTH];
	int                           tally_used = 0;
	bit                           tally_ovf  = 1'b0;

	dump_item_t dump_q [$];
	dump_item_t want;
	int         mismatches = 0;

	// Add or subtract one for a key, inserting or removing entries as needed
	function automatic void apply_delta(logic [KB-1:0] k, bit up);
		int     p;
		int     i;
		longint c;
		p = 0;
		while (p < tally_used && tally_key[p] < k)
			p++;
		if (p < tally_used && tally_key[p] == k) begin
			c = tally_cnt[p];
			if (up) begin
				if (c < CNT_HI)
					c++;
			end else if (c > CNT_LO) begin
				c--;
			end
			tally_cnt[p] = c[COUNT_BITS-1:0];
			if (c == 0) begin
				for (i = p; i + 1 < tally_used; i++) begin
					tally_key[i] = tally_key[i + 1];
					tally_cnt[i] = tally_cnt[i + 1];
				end
				tally_used--;
			end
			return;
		end
		if (tally_used >= TABLE_DEPTH) begin
			tally_ovf = 1'b1;
			return;
		end
		for (i = tally_used; i > p; i--) begin
			tally_key[i] = tally_key[i - 1];
			tally_cnt[i] = tally_cnt[i - 1];
		end
		tally_key[p] = k;
		tally_cnt[p] = up ? COUNT_BITS'(1) : COUNT_BITS'(-1);
		tally_used++;
	endfunction

	// Queue one item per positive entry in key order (one empty item if none), mark the last, then clear the table
	function automatic void queue_dump();
		dump_item_t held;
		dump_item_t it;
		bit         have;
		longint     c;
		int         i;
		have = 1'b0;
		held = '0;
		for (i = 0; i < tally_used; i++) begin
			c = tally_cnt[i];
			if (c > 0) begin
				it.key   = tally_key[i];
				it.cnt   = (c > longint'(scm_pkg::OUT_COUNT_MAX)) ?
					scm_pkg::OUT_COUNT_MAX : c[OCB-1:0];
				it.valid = 1'b1;
				it.ovf   = tally_ovf;
				it.last  = 1'b0;
				if (have)
					dump_q.insert(dump_q.size(), held);
				held = it;
				have = 1'b1;
			end
		end
		if (!have) begin
			held     = '0;
			held.ovf = tally_ovf;
		end
		held.last = 1'b1;
		dump_q.insert(dump_q.size(), held);
		tally_used = 0;
	endfunction

	function automatic void take_number(logic [31:0] v);
		logic [31:0] mag;
		mag = 32'd0 - v;
		if (v == 32'd0)
			queue_dump();
		else if (v != 32'h8000_0000) begin
			if (!v[31])
				apply_delta(v[KB-1:0], 1'b1);
			else
				apply_delta(mag[KB-1:0], 1'b0);
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("t=%0t %s mismatch: expected %0d (0x%h), got %0d (0x%h)",
				$time, name, exp_v, exp_v, act_v, act_v);
			mismatches++;
		end
	endfunction

	// Compare finished dump items first, then fold in the newly accepted request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_used = 0;
			tally_ovf  = 1'b0;
			dump_q.delete();
			pending <= 0;
			errors  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (dump_q.size() == 0) begin
					$display("t=%0t unexpected dump item: expected none, got tdata=0x%h tuser=%b tlast=%b",
						$time, m_tdata, m_tuser, m_tlast);
					mismatches++;
				end else begin
					want = dump_q.pop_front();
					check_field("key_value", 32'(want.key), 32'(m_tdata[KB-1:0]));
					check_field("key_count", 32'(want.cnt), 32'(m_tdata[KB+OCB-1:KB]));
					check_field("item_valid", 32'(want.valid), 32'(m_tuser[0]));
					check_field("table_overflow", 32'(want.ovf), 32'(m_tuser[1]));
					check_field("last_item", 32'(want.last), 32'(m_tlast));
				end
			end
			if (s_tvalid && s_tready)
				take_number(s_tdata);
			pending <= dump_q.size();
			errors  <= mismatches;
		end
	end

endmodule

### verif/tb_sorted_counting_multiset.sv
// Testbench top for the sorted counting multiset: clock, reset, request and result traffic, verdict.
module tb_sorted_counting_multiset;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int OVF_AT       = 300;
	localparam int TOTAL_ITEMS  = 470;
	localparam int LONG_HOLD_AT = 12;
	localparam int LONG_HOLD    = 500;
	localparam int DRAIN_CYCLES = 300;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [31:0]                    s_tdata  = 32'd0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [scm_pkg::TDATA_BITS-1:0] m_tdata;
	logic [scm_pkg::TUSER_BITS-1:0] m_tuser;
	logic                           m_tlast;

	int errors;
	int pending;
	int sent        = 0;
	int cycle_count = 0;
	bit tx_burst    = 1'b0;
	bit rx_burst    = 1'b0;

	// Opening sequence: empty dump, ignored most-negative value, extreme keys,
	// count back to zero, remove of absent key, negative counts at a dump
	logic [31:0] opening_seq [19] = '{
		32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001,
		32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'h0000_0005, 32'hFFFF_FFF7, 32'h0000_03E8,
		32'h8000_0001, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0003,
		32'hFFFF_FFFD, 32'hFFFF_FFFD, 32'hFFFF_FFFD, 32'h0000_0000
	};

	sorted_counting_multiset dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	multiset_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [30:0] fresh_key();
		logic [30:0] k;
		case ($urandom_range(0, 3))
			0, 1: k = 31'($urandom_range(1, 40));
			2: begin
				k = 31'($urandom);
				if (k == 31'd0)
					k = 31'd1;
			end
			default: k = 31'h7FFF_FFFF - 31'($urandom_range(0, 15));
		endcase
		return k;
	endfunction

	function automatic logic [31:0] negate_key(logic [30:0] k);
		return 32'd0 - {1'b0, k};
	endfunction

	// Offer one request after a random gap and hold it until accepted
	task automatic offer_number(input logic [31:0] v);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 4);
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		@(posedge clk);
		while (!(s_tvalid && s_tready))
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// Adds and removes over a small key pool, with some noise, closed by a dump
	task automatic run_frame();
		logic [30:0] pool [16];
		int          pool_n;
		int          n_ops;
		int          i;
		int          r;
		logic [30:0] k;
		pool_n = $urandom_range(1, 16);
		n_ops  = $urandom_range(1, 20);
		for (i = 0; i < pool_n; i++)
			pool[i] = fresh_key();
		for (i = 0; i < n_ops; i++) begin
			r = $urandom_range(0, 99);
			k = pool[$urandom_range(0, pool_n - 1)];
			if (r < 62)
				offer_number({1'b0, k});
			else if (r < 85)
				offer_number(negate_key(k));
			else if (r < 89)
				offer_number(32'h8000_0000);
			else if (r < 97)
				offer_number($urandom);
			else
				offer_number(32'd0);
		end
		offer_number(32'd0);
	endtask

	// Push more distinct keys than the table holds, then dump the full table
	task automatic overflow_frame();
		int i;
		for (i = 0; i < 70; i++)
			offer_number(32'(((i * 37) % 70) * 1000 + $urandom_range(1, 999)));
		for (i = 0; i < 4; i++)
			offer_number(32'($urandom_range(1, 69999)));
		offer_number(32'd0);
	endtask

	// Result side: random stalls, one long hold-off to back up the input
	initial begin
		int stall;
		int taken;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if (taken == LONG_HOLD_AT)
				stall = LONG_HOLD;
			else
				stall = rx_burst ? 0 : $urandom_range(0, 4);
			if ($urandom_range(0, 29) == 0)
				rx_burst = !rx_burst;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!(m_tvalid && m_tready))
				@(posedge clk);
			taken++;
			@(negedge clk);
		end
	end

	// Request side and verdict
	initial begin
		int i;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (i = 0; i < 19; i++)
			offer_number(opening_seq[i]);
		while (sent < OVF_AT)
			run_frame();
		overflow_frame();
		while (sent < TOTAL_ITEMS)
			run_frame();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### filelist.f
rtl/core/scm_pkg.sv
rtl/core/scm_ram.sv
rtl/core/sorted_counting_multiset.sv
verif/multiset_checker.sv
verif/tb_sorted_counting_multiset.sv
